// ----- src/rule_language_tokenizer_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef RULE_LANGUAGE_TOKENIZER_MACROS_SVH
`define RULE_LANGUAGE_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define RLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlt: assertion failed");
`define RLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlt: assertion failed");
`else
`define RLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/rlt_pkg.sv -----
// Shared types and constants of the rule language tokenizer.
package rlt_pkg;

  localparam int unsigned FLD_W      = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef enum logic [3:0] {
    K_IDENT    = 4'd0,
    K_INT      = 4'd1,
    K_SEMI     = 4'd2,
    K_COLON    = 4'd3,
    K_ARROW    = 4'd4,
    K_LPAREN   = 4'd5,
    K_RPAREN   = 4'd6,
    K_LBRACKET = 4'd7,
    K_RBRACKET = 4'd8,
    K_COMMA    = 4'd9,
    K_CMP      = 4'd10,
    K_END      = 4'd11,
    K_ERROR    = 4'd12
  } kind_e;

  localparam logic [2:0] OP_EQ = 3'd0;
  localparam logic [2:0] OP_NE = 3'd1;
  localparam logic [2:0] OP_LT = 3'd2;
  localparam logic [2:0] OP_LE = 3'd3;
  localparam logic [2:0] OP_GT = 3'd4;
  localparam logic [2:0] OP_GE = 3'd5;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_US     = 8'h5f;

  typedef struct packed {
    kind_e            kind;
    logic [2:0]       op;
    logic [FLD_W-1:0] line;
    logic [FLD_W-1:0] col;
    logic [FLD_W-1:0] len;
    logic             last;
  } result_t;

  // Up to two results caused by one accepted item; v1 only with v0.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } emit_t;

endpackage

// ----- src/rlt_scan.sv -----
// Scanner state and per-item token decode of the rule language tokenizer.
`include "rule_language_tokenizer_macros.svh"

module rlt_scan #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  logic            cmd_i,
  input  logic [7:0]      chr_i,
  output rlt_pkg::emit_t  emit_o
);

  typedef enum logic [9:0] {
    M_IDLE    = 10'b00_0000_0001,
    M_IDENT   = 10'b00_0000_0010,
    M_INT     = 10'b00_0000_0100,
    M_COMMENT = 10'b00_0000_1000,
    M_MINUS   = 10'b00_0001_0000,
    M_EQ      = 10'b00_0010_0000,
    M_BANG    = 10'b00_0100_0000,
    M_LT      = 10'b00_1000_0000,
    M_GT      = 10'b01_0000_0000,
    M_ERROR   = 10'b10_0000_0000
  } mode_e;

  localparam logic [POS_WIDTH-1:0]     POS_ONE = POS_WIDTH'(1);
  localparam logic [POS_WIDTH-1:0]     POS_MAX = {POS_WIDTH{1'b1}};
  localparam logic [rlt_pkg::FLD_W-1:0] LEN_MAX = {rlt_pkg::FLD_W{1'b1}};

  mode_e                      mode_q, mode_d;
  logic [POS_WIDTH-1:0]       line_q, line_d, col_q, col_d;
  logic [POS_WIDTH-1:0]       tline_q, tline_d, tcol_q, tcol_d;
  logic [rlt_pkg::FLD_W-1:0]  tlen_q, tlen_d;

  logic [rlt_pkg::FLD_W-1:0]  cur_line, cur_col, tok_line, tok_col;
  logic                       is_alpha, is_digit, is_space;
  logic                       punct_v;
  rlt_pkg::kind_e             punct_k;

  logic                       sub_v, sub_begin, sub_step;
  mode_e                      sub_mode;
  rlt_pkg::result_t           sub_r;

  logic                       flush_v, sec_v, step, start, len_inc, clear;
  rlt_pkg::result_t           flush_r, sec_r;

  function automatic rlt_pkg::result_t mk(rlt_pkg::kind_e k, logic [2:0] op,
                                          logic [rlt_pkg::FLD_W-1:0] ln,
                                          logic [rlt_pkg::FLD_W-1:0] cl,
                                          logic [rlt_pkg::FLD_W-1:0] len);
    rlt_pkg::result_t r;
    r.kind = k;
    r.op   = op;
    r.line = ln;
    r.col  = cl;
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

  assign cur_line = rlt_pkg::FLD_W'(line_q);
  assign cur_col  = rlt_pkg::FLD_W'(col_q);
  assign tok_line = rlt_pkg::FLD_W'(tline_q);
  assign tok_col  = rlt_pkg::FLD_W'(tcol_q);

  assign is_alpha = (chr_i >= 8'h61 && chr_i <= 8'h7a) || (chr_i >= 8'h41 && chr_i <= 8'h5a);
  assign is_digit = chr_i >= 8'h30 && chr_i <= 8'h39;
  assign is_space = chr_i == rlt_pkg::CH_SPACE ||
                    (chr_i >= rlt_pkg::CH_TAB && chr_i <= rlt_pkg::CH_CR);

  always_comb begin
    punct_v = 1'b1;
    punct_k = rlt_pkg::K_SEMI;
    unique case (chr_i)
      rlt_pkg::CH_SEMI:   punct_k = rlt_pkg::K_SEMI;
      rlt_pkg::CH_COLON:  punct_k = rlt_pkg::K_COLON;
      rlt_pkg::CH_LPAREN: punct_k = rlt_pkg::K_LPAREN;
      rlt_pkg::CH_RPAREN: punct_k = rlt_pkg::K_RPAREN;
      rlt_pkg::CH_LBRACK: punct_k = rlt_pkg::K_LBRACKET;
      rlt_pkg::CH_RBRACK: punct_k = rlt_pkg::K_RBRACKET;
      rlt_pkg::CH_COMMA:  punct_k = rlt_pkg::K_COMMA;
      default:            punct_v = 1'b0;
    endcase
  end

  // Scan a byte as if between tokens, at the current position.
  always_comb begin
    sub_v     = 1'b0;
    sub_begin = 1'b0;
    sub_step  = 1'b0;
    sub_mode  = M_IDLE;
    sub_r     = mk(rlt_pkg::K_ERROR, rlt_pkg::OP_EQ, cur_line, cur_col, '0);
    priority if (is_space) begin
      sub_step = 1'b1;
    end else if (chr_i == rlt_pkg::CH_HASH) begin
      sub_mode = M_COMMENT;
      sub_step = 1'b1;
    end else if (is_alpha || chr_i == rlt_pkg::CH_US) begin
      sub_mode  = M_IDENT;
      sub_begin = 1'b1;
      sub_step  = 1'b1;
    end else if (is_digit) begin
      sub_mode  = M_INT;
      sub_begin = 1'b1;
      sub_step  = 1'b1;
    end else if (chr_i == rlt_pkg::CH_MINUS) begin
      sub_mode  = M_MINUS;
      sub_begin = 1'b1;
      sub_step  = 1'b1;
    end else if (chr_i == rlt_pkg::CH_EQ) begin
      sub_mode  = M_EQ;
      sub_begin = 1'b1;
      sub_step  = 1'b1;
    end else if (chr_i == rlt_pkg::CH_BANG) begin
      sub_mode  = M_BANG;
      sub_begin = 1'b1;
      sub_step  = 1'b1;
    end else if (chr_i == rlt_pkg::CH_LT) begin
      sub_mode  = M_LT;
      sub_begin = 1'b1;
      sub_step  = 1'b1;
    end else if (chr_i == rlt_pkg::CH_GT) begin
      sub_mode  = M_GT;
      sub_begin = 1'b1;
      sub_step  = 1'b1;
    end else if (punct_v) begin
      sub_v    = 1'b1;
      sub_r    = mk(punct_k, rlt_pkg::OP_EQ, cur_line, cur_col, rlt_pkg::FLD_W'(1));
      sub_step = 1'b1;
    end else begin
      // unexpected byte: error at its own position, position held
      sub_v    = 1'b1;
      sub_mode = M_ERROR;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    flush_v = 1'b0;
    flush_r = mk(rlt_pkg::K_END, rlt_pkg::OP_EQ, cur_line, cur_col, '0);
    sec_v   = 1'b0;
    sec_r   = sub_r;
    step    = 1'b0;
    start   = 1'b0;
    len_inc = 1'b0;
    clear   = 1'b0;
    if (acc_i && cmd_i) begin
      clear = 1'b1;
      unique case (mode_q)
        M_ERROR: ;
        M_IDENT, M_INT: begin
          flush_v = 1'b1;
          flush_r = mk(mode_q == M_IDENT ? rlt_pkg::K_IDENT : rlt_pkg::K_INT,
                       rlt_pkg::OP_EQ, tok_line, tok_col, tlen_q);
          sec_v   = 1'b1;
          sec_r   = mk(rlt_pkg::K_END, rlt_pkg::OP_EQ, cur_line, cur_col, '0);
        end
        M_LT, M_GT: begin
          flush_v = 1'b1;
          flush_r = mk(rlt_pkg::K_CMP, mode_q == M_LT ? rlt_pkg::OP_LT : rlt_pkg::OP_GT,
                       tok_line, tok_col, rlt_pkg::FLD_W'(1));
          sec_v   = 1'b1;
          sec_r   = mk(rlt_pkg::K_END, rlt_pkg::OP_EQ, cur_line, cur_col, '0);
        end
        M_MINUS, M_EQ, M_BANG: begin
          flush_v = 1'b1;
          flush_r = mk(rlt_pkg::K_ERROR, rlt_pkg::OP_EQ, tok_line, tok_col, '0);
        end
        default: begin
          flush_v = 1'b1;
        end
      endcase
    end else if (acc_i) begin
      unique case (mode_q)
        M_IDLE: begin
          sec_v  = sub_v;
          mode_d = sub_mode;
          start  = sub_begin;
          step   = sub_step;
        end
        M_COMMENT: begin
          if (chr_i == rlt_pkg::CH_NL) begin
            mode_d = M_IDLE;
          end
          step = 1'b1;
        end
        M_IDENT, M_INT: begin
          if ((mode_q == M_IDENT && (is_alpha || is_digit || chr_i == rlt_pkg::CH_US)) ||
              (mode_q == M_INT && is_digit)) begin
            len_inc = 1'b1;
            step    = 1'b1;
          end else begin
            // emit the pending token, then rescan this byte
            flush_v = 1'b1;
            flush_r = mk(mode_q == M_IDENT ? rlt_pkg::K_IDENT : rlt_pkg::K_INT,
                         rlt_pkg::OP_EQ, tok_line, tok_col, tlen_q);
            sec_v   = sub_v;
            mode_d  = sub_mode;
            start   = sub_begin;
            step    = sub_step;
          end
        end
        M_MINUS, M_EQ, M_BANG: begin
          flush_v = 1'b1;
          if (chr_i == (mode_q == M_MINUS ? rlt_pkg::CH_GT : rlt_pkg::CH_EQ)) begin
            if (mode_q == M_MINUS) begin
              flush_r = mk(rlt_pkg::K_ARROW, rlt_pkg::OP_EQ, tok_line, tok_col,
                           rlt_pkg::FLD_W'(2));
            end else begin
              flush_r = mk(rlt_pkg::K_CMP, mode_q == M_EQ ? rlt_pkg::OP_EQ : rlt_pkg::OP_NE,
                           tok_line, tok_col, rlt_pkg::FLD_W'(2));
            end
            step   = 1'b1;
            mode_d = M_IDLE;
          end else begin
            flush_r = mk(rlt_pkg::K_ERROR, rlt_pkg::OP_EQ, tok_line, tok_col, '0);
            mode_d  = M_ERROR;
          end
        end
        M_LT, M_GT: begin
          flush_v = 1'b1;
          if (chr_i == rlt_pkg::CH_EQ) begin
            flush_r = mk(rlt_pkg::K_CMP, mode_q == M_LT ? rlt_pkg::OP_LE : rlt_pkg::OP_GE,
                         tok_line, tok_col, rlt_pkg::FLD_W'(2));
            step    = 1'b1;
            mode_d  = M_IDLE;
          end else begin
            flush_r = mk(rlt_pkg::K_CMP, mode_q == M_LT ? rlt_pkg::OP_LT : rlt_pkg::OP_GT,
                         tok_line, tok_col, rlt_pkg::FLD_W'(1));
            sec_v   = sub_v;
            mode_d  = sub_mode;
            start   = sub_begin;
            step    = sub_step;
          end
        end
        M_ERROR: ;
        default: mode_d = M_IDLE;
      endcase
    end
  end

  always_comb begin
    line_d  = line_q;
    col_d   = col_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    tlen_d  = tlen_q;
    if (clear) begin
      line_d  = POS_ONE;
      col_d   = POS_ONE;
      tline_d = POS_ONE;
      tcol_d  = POS_ONE;
      tlen_d  = '0;
    end else begin
      if (start) begin
        tline_d = line_q;
        tcol_d  = col_q;
        tlen_d  = rlt_pkg::FLD_W'(1);
      end else if (len_inc && tlen_q != LEN_MAX) begin
        tlen_d = tlen_q + rlt_pkg::FLD_W'(1);
      end
      if (step) begin
        if (chr_i == rlt_pkg::CH_NL) begin
          if (line_q != POS_MAX) begin
            line_d = line_q + POS_ONE;
          end
          col_d = POS_ONE;
        end else if (col_q != POS_MAX) begin
          col_d = col_q + POS_ONE;
        end
      end
    end
  end

  always_comb begin
    emit_o.v0      = flush_v | sec_v;
    emit_o.v1      = flush_v & sec_v;
    emit_o.r0      = flush_v ? flush_r : sec_r;
    emit_o.r0.last = ~(flush_v & sec_v);
    emit_o.r1      = sec_r;
    emit_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      line_q  <= POS_ONE;
      col_q   <= POS_ONE;
      tline_q <= POS_ONE;
      tcol_q  <= POS_ONE;
      tlen_q  <= '0;
    end else begin
      mode_q  <= clear ? M_IDLE : mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      tlen_q  <= tlen_d;
    end
  end

  `RLT_ASSERT_NXT(a_err_sticky, clk_i, rst_ni, mode_q == M_ERROR && !(acc_i && cmd_i), mode_q == M_ERROR)
  `RLT_ASSERT_NXT(a_end_resets, clk_i, rst_ni, acc_i && cmd_i, line_q == POS_ONE && col_q == POS_ONE && mode_q == M_IDLE)
  `RLT_ASSERT_IMP(a_no_emit_idle, clk_i, rst_ni, !acc_i, !emit_o.v0)

endmodule

// ----- src/rlt_fifo.sv -----
// Four-entry result queue, up to two pushes and one pop per cycle.
`include "rule_language_tokenizer_macros.svh"

module rlt_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rlt_pkg::emit_t   push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output rlt_pkg::result_t head_o
);

  rlt_pkg::result_t                mem_q [rlt_pkg::FIFO_DEPTH];
  logic [rlt_pkg::PTR_W-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [rlt_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                            pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rptr_q];
  // keep space for the two results one item may cause
  assign room_o  = cnt_q <= rlt_pkg::CNT_W'(rlt_pkg::FIFO_DEPTH - 2);

  always_comb begin
    wptr_d = wptr_q + rlt_pkg::PTR_W'(push_i.v0) + rlt_pkg::PTR_W'(push_i.v1);
    rptr_d = rptr_q + rlt_pkg::PTR_W'(pop);
    cnt_d  = cnt_q + rlt_pkg::CNT_W'(push_i.v0) + rlt_pkg::CNT_W'(push_i.v1)
           - rlt_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wptr_q + rlt_pkg::PTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  `RLT_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= rlt_pkg::CNT_W'(rlt_pkg::FIFO_DEPTH))
  `RLT_ASSERT_IMP(a_pair_order, clk_i, rst_ni, push_i.v1, push_i.v0)
  `RLT_ASSERT_IMP(a_push_room, clk_i, rst_ni, push_i.v0, room_o)

endmodule

// ----- src/rule_language_tokenizer.sv -----
// Top level of the rule language tokenizer: stream ports, scanner and result queue.
// A result is written into the queue at the clock edge that accepts the item causing it.
// Throughput: one item per cycle while each item gives at most one result and the
// queue has room; an item that flushes a pending token and gives its own puts two
// results into the four-entry queue, which delivers one result per cycle while m_axis_tready is high.
// Reset (rst_ni low, asynchronous): scanner idle at line 1, column 1; queue empty.
module rule_language_tokenizer #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
  input  logic [0:0]  s_axis_tuser,  // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // [2:0] compare_op, [18:3] start_line,
                                     // [34:19] start_column, [50:35] token_length
  output logic [3:0]  m_axis_tuser,  // [3:0] token_kind
  output logic        m_axis_tlast   // last_of_run
);

  logic             acc;
  rlt_pkg::emit_t   emit;
  rlt_pkg::result_t head;

  assign acc = s_axis_tvalid & s_axis_tready;

  rlt_scan #(
    .POS_WIDTH(POS_WIDTH)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .acc_i (acc),
    .cmd_i (s_axis_tuser[0]),
    .chr_i (s_axis_tdata),
    .emit_o(emit)
  );

  rlt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (emit),
    .room_o (s_axis_tready),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .head_o (head)
  );

  assign m_axis_tdata = {5'b0, head.len, head.col, head.line, head.op};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
